// File: sv/assert_macros.svh
// Assertion macros shared by the distance pipeline RTL.
// Needs clk_i and rst_ni in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define GCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define GCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: sv/gcd_pkg.sv
// Shared widths, constants and the CORDIC arctangent table.
// No dependencies.
`default_nettype none
package gcd_pkg;

  localparam int unsigned CORDIC_STAGES = 28;
  localparam int unsigned FRAC_BITS     = 30;
  localparam int unsigned MAG_W         = 31;  // |cos|, |sin|, half-angle
  localparam int unsigned ROT_W         = 33;  // rotation x/y
  localparam int unsigned VEC_W         = 36;  // vectoring x/y
  localparam int unsigned ANG_W         = 33;  // angle accumulator

  // round(pi * 2^71 / 1.8e9): 1e-7 degree to Q30 half-angle, after >> 42
  localparam logic [41:0] UNIT_TO_RAD = 42'd4121042180595;

  // atan(2^-i) in Q30, rounded to nearest
  function automatic logic signed [ANG_W-1:0] atan_q(input int unsigned i);
    logic signed [ANG_W-1:0] r;
    case (i)
      0:       r = ANG_W'(843314857);
      1:       r = ANG_W'(497837829);
      2:       r = ANG_W'(263043837);
      3:       r = ANG_W'(133525159);
      4:       r = ANG_W'(67021687);
      5:       r = ANG_W'(33543516);
      6:       r = ANG_W'(16775851);
      7:       r = ANG_W'(8388437);
      8:       r = ANG_W'(4194283);
      9:       r = ANG_W'(2097149);
      default: r = (i < FRAC_BITS) ? ANG_W'(64'd1 << (FRAC_BITS - i)) : '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/gcd_rot_pipe.sv
// Rotation CORDIC, one register stage per iteration: |cos|, |sin| of z.
// Depends on gcd_pkg. Gain is left in the outputs.
`default_nettype none
module gcd_rot_pipe (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  logic                                    valid_i,
  input  logic signed [gcd_pkg::ANG_W-1:0]        z_i,
  output logic                                    valid_o,
  output logic        [gcd_pkg::MAG_W-1:0]        cos_o,
  output logic        [gcd_pkg::MAG_W-1:0]        sin_o
);

  localparam int unsigned N = gcd_pkg::CORDIC_STAGES;
  localparam int unsigned XW = gcd_pkg::ROT_W;
  localparam int unsigned ZW = gcd_pkg::ANG_W;
  localparam logic signed [XW-1:0] X_ONE = XW'(64'd1 << gcd_pkg::FRAC_BITS);

  logic signed [XW-1:0] x_q [N];
  logic signed [XW-1:0] y_q [N];
  logic signed [ZW-1:0] z_q [N];
  logic                 v_q [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [XW-1:0] x_in, y_in;
    logic signed [ZW-1:0] z_in;
    logic                 v_in;
    if (i == 0) begin : g_first
      assign x_in = X_ONE;
      assign y_in = '0;
      assign z_in = z_i;
      assign v_in = valid_i;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
      assign v_in = v_q[i-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (z_in >= 0) begin
          x_q[i] <= x_in - (y_in >>> i);
          y_q[i] <= y_in + (x_in >>> i);
          z_q[i] <= z_in - gcd_pkg::atan_q(i);
        end else begin
          x_q[i] <= x_in + (y_in >>> i);
          y_q[i] <= y_in - (x_in >>> i);
          z_q[i] <= z_in + gcd_pkg::atan_q(i);
        end
      end
    end
  end

  logic signed [XW-1:0] x_abs, y_abs;
  assign x_abs = x_q[N-1][XW-1] ? -x_q[N-1] : x_q[N-1];
  assign y_abs = y_q[N-1][XW-1] ? -y_q[N-1] : y_q[N-1];

  assign valid_o = v_q[N-1];
  assign cos_o   = x_abs[gcd_pkg::MAG_W-1:0];
  assign sin_o   = y_abs[gcd_pkg::MAG_W-1:0];

endmodule
`default_nettype wire

// File: sv/gcd_vec_pipe.sv
// Vectoring CORDIC, one register stage per iteration: magnitude and angle.
// Depends on gcd_pkg. Magnitude keeps the CORDIC gain.
`default_nettype none
module gcd_vec_pipe (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  logic                                    valid_i,
  input  logic signed [gcd_pkg::VEC_W-1:0]        x_i,
  input  logic signed [gcd_pkg::VEC_W-1:0]        y_i,
  output logic                                    valid_o,
  output logic signed [gcd_pkg::VEC_W-1:0]        x_o,
  output logic signed [gcd_pkg::ANG_W-1:0]        z_o
);

  localparam int unsigned N  = gcd_pkg::CORDIC_STAGES;
  localparam int unsigned XW = gcd_pkg::VEC_W;
  localparam int unsigned ZW = gcd_pkg::ANG_W;

  logic signed [XW-1:0] x_q [N];
  logic signed [XW-1:0] y_q [N];
  logic signed [ZW-1:0] z_q [N];
  logic                 v_q [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [XW-1:0] x_in, y_in;
    logic signed [ZW-1:0] z_in;
    logic                 v_in;
    if (i == 0) begin : g_first
      assign x_in = x_i;
      assign y_in = y_i;
      assign z_in = '0;
      assign v_in = valid_i;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
      assign v_in = v_q[i-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_in >= 0) begin
          x_q[i] <= x_in + (y_in >>> i);
          y_q[i] <= y_in - (x_in >>> i);
          z_q[i] <= z_in + gcd_pkg::atan_q(i);
        end else begin
          x_q[i] <= x_in - (y_in >>> i);
          y_q[i] <= y_in + (x_in >>> i);
          z_q[i] <= z_in - gcd_pkg::atan_q(i);
        end
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign x_o     = x_q[N-1];
  assign z_o     = z_q[N-1];

endmodule
`default_nettype wire

// File: sv/great_circle_distance.sv
// Haversine great-circle distance, fully pipelined fixed-point datapath.
// Depends on gcd_pkg, gcd_rot_pipe, gcd_vec_pipe and assert_macros.svh.
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------
//   in      | in_valid_i/in_ready_o  | lat_a_i, lon_a_i, lat_b_i, lon_b_i
//   out     | out_valid_o/out_ready_i| distance_cm_o
//   cfg     | cfg_we_i (no wait)     | earth_radius_m_i
//
// One request per cycle. There are 4 input/angle stages, 28 rotation
// CORDIC stages, 1 product stage, 2 x 28 vectoring stages, 1 scale stage
// and the output register. All stages advance together: they hold while
// the output register keeps an untaken result. Reset clears the valid
// bits and loads the radius with 6371000 m; no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module great_circle_distance (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic        [22:0] earth_radius_m_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [30:0] lat_a_i,
  input  logic signed [31:0] lon_a_i,
  input  logic signed [30:0] lat_b_i,
  input  logic signed [31:0] lon_b_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic        [30:0] distance_cm_o
);

  localparam int unsigned MW = gcd_pkg::MAG_W;
  localparam int unsigned VW = gcd_pkg::VEC_W;
  localparam int unsigned AW = gcd_pkg::ANG_W;
  localparam logic signed [34:0] HALF_TURN = 35'sd1800000000;
  localparam logic signed [34:0] TURN      = 35'sd3600000000;
  localparam logic [29:0] RAD100_RST = 30'd637100000;
  localparam logic [31:0] DIST_MAX   = 32'h7FFF_FFFF;

  // wrap into (-180, 180] degrees of half-angle units, then magnitude
  function automatic logic [MW-1:0] wrap_mag(input logic signed [34:0] u);
    logic signed [34:0] m;
    logic signed [34:0] a;
    m = u;
    if (u > HALF_TURN) begin
      m = u - TURN;
    end else if (u <= -HALF_TURN) begin
      m = u + TURN;
    end
    a = m[34] ? -m : m;
    return a[MW-1:0];
  endfunction

  // round(a*b / 2^30), half up
  function automatic logic signed [VW-1:0] mul_rnd(input logic [MW-1:0] a,
                                                   input logic [MW-1:0] b);
    logic [62:0] p;
    p = 63'(a) * 63'(b) + (63'd1 << (gcd_pkg::FRAC_BITS - 1));
    return VW'(p >> gcd_pkg::FRAC_BITS);
  endfunction

  // ---------------------------------------------------------------------
  // Global advance: whole pipe moves unless the output result is stalled.
  logic en;
  assign en         = out_ready_i || !out_valid_o;
  assign in_ready_o = en;

  // Radius register, kept pre-scaled to centimetres.
  logic [29:0] rad100_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad100_q <= RAD100_RST;
    end else if (cfg_we_i) begin
      rad100_q <= 30'(earth_radius_m_i) * 30'd100;
    end
  end

  // Stage A: angle sums and differences (in units of 1e-7 degree).
  logic               v_a_q;
  logic signed [31:0] d_lat_q;
  logic signed [32:0] d_lon_q;
  logic signed [31:0] s_lat_q;

  // Stage B: wrapped magnitudes.
  logic          v_b_q;
  logic [MW-1:0] mag_dl_q, mag_dn_q, mag_m_q;

  // Stage C: partial products against the 42-bit conversion constant.
  logic        v_c_q;
  logic [62:0] lo_q [3];
  logic [40:0] hi_q [3];

  // Stage D: Q30 half-angles.
  logic          v_d_q;
  logic [MW-1:0] z_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
      v_c_q <= 1'b0;
      v_d_q <= 1'b0;
    end else if (en) begin
      v_a_q <= in_valid_i;
      v_b_q <= v_a_q;
      v_c_q <= v_b_q;
      v_d_q <= v_c_q;
    end
  end

  logic [MW-1:0] mags [3];
  assign mags[0] = mag_dl_q;
  assign mags[1] = mag_dn_q;
  assign mags[2] = mag_m_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_lat_q  <= 32'(lat_b_i) - 32'(lat_a_i);
      d_lon_q  <= 33'(lon_b_i) - 33'(lon_a_i);
      s_lat_q  <= 32'(lat_a_i) + 32'(lat_b_i);
      mag_dl_q <= wrap_mag(35'(d_lat_q));
      mag_dn_q <= wrap_mag(35'(d_lon_q));
      mag_m_q  <= wrap_mag(35'(s_lat_q));
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_conv
    logic [72:0] full;
    assign full = {hi_q[k], 32'd0} + 73'(lo_q[k]) + (73'd1 << 41);
    always_ff @(posedge clk_i) begin
      if (en) begin
        lo_q[k] <= 63'(mags[k]) * 63'(gcd_pkg::UNIT_TO_RAD[31:0]);
        hi_q[k] <= 41'(mags[k]) * 41'(gcd_pkg::UNIT_TO_RAD[41:32]);
        z_q[k]  <= full[72:42];
      end
    end
  end

  // Half-angle sines and cosines.
  logic          rv [3];
  logic [MW-1:0] cs [3];
  logic [MW-1:0] sn [3];

  for (genvar k = 0; k < 3; k++) begin : g_rot
    gcd_rot_pipe u_rot (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v_d_q),
      .z_i     (AW'(z_q[k])),
      .valid_o (rv[k]),
      .cos_o   (cs[k]),
      .sin_o   (sn[k])
    );
  end

  // Stage E: the four haversine products.
  logic                 v_e_q;
  logic signed [VW-1:0] hx_q, hy_q, gx_q, gy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_e_q <= 1'b0;
    end else if (en) begin
      v_e_q <= rv[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hx_q <= mul_rnd(sn[0], cs[1]);  // sin(dlat/2) cos(dlon/2)
      hy_q <= mul_rnd(cs[2], sn[1]);  // cos(mlat) sin(dlon/2)
      gx_q <= mul_rnd(cs[0], cs[1]);  // cos(dlat/2) cos(dlon/2)
      gy_q <= mul_rnd(sn[2], sn[1]);  // sin(mlat) sin(dlon/2)
    end
  end

  // sqrt(a) and sqrt(1-a) as CORDIC magnitudes, in parallel.
  logic                 hv, gv;
  logic signed [VW-1:0] h_mag, g_mag;
  logic signed [AW-1:0] h_ang, g_ang;

  gcd_vec_pipe u_vec_h (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_e_q),
    .x_i     (hx_q),
    .y_i     (hy_q),
    .valid_o (hv),
    .x_o     (h_mag),
    .z_o     (h_ang)
  );

  gcd_vec_pipe u_vec_g (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_e_q),
    .x_i     (gx_q),
    .y_i     (gy_q),
    .valid_o (gv),
    .x_o     (g_mag),
    .z_o     (g_ang)
  );

  // Half central angle: atan2(sqrt(a), sqrt(1-a)); gain cancels.
  logic                 cv;
  logic signed [VW-1:0] c_mag;
  logic signed [AW-1:0] c_ang;

  gcd_vec_pipe u_vec_c (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (hv),
    .x_i     (g_mag),
    .y_i     (h_mag),
    .valid_o (cv),
    .x_o     (c_mag),
    .z_o     (c_ang)
  );

  // Stage F: central angle (clamped at zero) times radius, rounded, saturated to 31 bits.
  logic        v_f_q;
  logic [31:0] dist_q;
  logic [31:0] c_full;
  logic [61:0] scaled;
  logic [32:0] dist_raw;

  assign c_full   = c_ang[AW-1] ? 32'd0 : {c_ang[30:0], 1'b0};
  assign scaled   = 62'(c_full) * 62'(rad100_q) + (62'd1 << (gcd_pkg::FRAC_BITS - 1));
  assign dist_raw = 33'(scaled >> gcd_pkg::FRAC_BITS);

  // Output register for the saturated 31-bit distance.
  logic        out_v_q;
  logic [30:0] out_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_f_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v_f_q   <= cv;
      out_v_q <= v_f_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q  <= (dist_raw > 33'(DIST_MAX)) ? DIST_MAX : dist_raw[31:0];
      out_d_q <= dist_q[30:0];
    end
  end

  assign out_valid_o   = out_v_q;
  assign distance_cm_o = out_d_q;

  // ---------------------------------------------------------------------
  `GCD_ASSERT(a_cfg_scale, cfg_we_i |=> rad100_q == 30'($past(earth_radius_m_i)) * 30'd100, "radius scale wrong")
  `GCD_ASSERT(a_hold_b, !en && v_b_q |=> $stable(mag_dl_q) && v_b_q, "stage B moved while held")
  `GCD_ASSERT_ALWAYS(a_rot_lockstep, rv[0] === rv[1] && rv[1] === rv[2], "rotation pipes out of step")
  `GCD_ASSERT_ALWAYS(a_vec_lockstep, hv === gv, "vectoring pipes out of step")

endmodule
`default_nettype wire

// File: bench/great_circle_distance_tb.sv
// Self-checking bench for the haversine distance pipeline.
// Needs gcd_pkg and the great_circle_distance RTL; no other files.
`timescale 1ns / 1ps
module great_circle_distance_tb;
  localparam int unsigned CORDIC_STAGES = gcd_pkg::CORDIC_STAGES;
  localparam int unsigned FRAC_BITS     = gcd_pkg::FRAC_BITS;

  localparam longint unsigned PI_Q62     = 64'hC90FDAA22168C235;
  localparam longint unsigned UNIT_DIV   = 64'd3515625;
  localparam longint          TURN       = 64'sd3600000000;
  localparam longint          HALF_TURN  = 64'sd1800000000;
  localparam longint unsigned DIST_SAT   = 64'h7FFFFFFF;
  localparam int              LATENCY    = 91;
  localparam longint          CYCLE_CAP  = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [22:0] earth_radius_m_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic signed [30:0] lat_a_i = '0;
  logic signed [31:0] lon_a_i = '0;
  logic signed [30:0] lat_b_i = '0;
  logic signed [31:0] lon_b_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [30:0] distance_cm_o;

  great_circle_distance i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .earth_radius_m_i(earth_radius_m_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .lat_a_i         (lat_a_i),
    .lon_a_i         (lon_a_i),
    .lat_b_i         (lat_b_i),
    .lon_b_i         (lon_b_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .distance_cm_o   (distance_cm_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Distance predictor: same fixed-point recipe as the pipeline
  // ---------------------------------------------------------------------
  longint          atan_q30 [CORDIC_STAGES];
  longint unsigned unit_to_rad;
  longint unsigned radius_m = 64'd6371000;   // mirror of the radius register

  // round half up of a*b / 2^sh, kept to 64 bits
  function automatic longint unsigned mul_round(longint unsigned a, longint unsigned b,
                                                int sh);
    logic [127:0] p;
    logic [127:0] q;
    p = {64'd0, a} * {64'd0, b};
    p = p + (128'd1 << (sh - 1));
    q = p >> sh;
    return q[63:0];
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // arctangent table: series summed in Q62, then rounded to Q30
  task automatic build_atan_table();
    longint t;
    longint term;
    longint unsigned u;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      t = 0;
      if (i == 0) begin
        t = longint'(PI_Q62 >> 2);
      end else begin
        for (int k = 0; (2 * k + 1) * i <= 62; k++) begin
          term = longint'((64'd1 << (62 - (2 * k + 1) * i)) / longint'(2 * k + 1));
          t = (k % 2) ? t - term : t + term;
        end
      end
      u = longint'(t) + (64'd1 << (61 - FRAC_BITS));
      atan_q30[i] = longint'(u >> (62 - FRAC_BITS));
    end
    unit_to_rad = (PI_Q62 + UNIT_DIV / 2) / UNIT_DIV;
  endtask

  // |cos| and |sin| of half an angle in 1e-7 degree, CORDIC gain kept
  task automatic half_angle_trig(longint units, output longint unsigned cs,
                                 output longint unsigned sn);
    longint m;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    m = units % TURN;
    if (m > HALF_TURN) m -= TURN;
    else if (m <= -HALF_TURN) m += TURN;
    z = longint'(mul_round(magnitude(m), unit_to_rad, 72 - FRAC_BITS));
    x = longint'(64'd1 << FRAC_BITS);
    y = 0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q30[i];
      end else begin
        x += dx; y -= dy; z += atan_q30[i];
      end
    end
    cs = magnitude(x);
    sn = magnitude(y);
  endtask

  // vectoring CORDIC: gain-scaled magnitude out, angle through ang
  task automatic vector_mode(longint xi, longint yi, output longint mag,
                             output longint ang);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    x = xi; y = yi; z = 0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_q30[i];
      end else begin
        x -= dx; y += dy; z -= atan_q30[i];
      end
    end
    mag = x;
    ang = z;
  endtask

  task automatic predict_distance(longint la, longint oa, longint lb, longint ob,
                                  output logic [30:0] dist_cm);
    longint unsigned c_dl, s_dl, c_dn, s_dn, c_m, s_m, d;
    longint h, g, ang, c, unused;
    half_angle_trig(lb - la, c_dl, s_dl);
    half_angle_trig(ob - oa, c_dn, s_dn);
    half_angle_trig(la + lb, c_m, s_m);
    // a and 1-a as sums of squares, so the clamp to [0,1] is implicit
    vector_mode(longint'(mul_round(s_dl, c_dn, FRAC_BITS)),
                longint'(mul_round(c_m, s_dn, FRAC_BITS)), h, unused);
    vector_mode(longint'(mul_round(c_dl, c_dn, FRAC_BITS)),
                longint'(mul_round(s_m, s_dn, FRAC_BITS)), g, unused);
    vector_mode(g, h, unused, ang);
    c = 2 * ang;
    if (c < 0) c = 0;   // tiny negative central angle
    d = mul_round(longint'(c), radius_m * 100, FRAC_BITS);
    if (d > DIST_SAT) d = DIST_SAT;
    dist_cm = d[30:0];
  endtask

  // ---------------------------------------------------------------------
  // Shared state
  // ---------------------------------------------------------------------
  logic [30:0] pending_dist_q[$];   // predicted distances, oldest first
  int          errors = 0;
  longint      cycles = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  logic        rx_hold_req = 1'b0;  // asks the receiver for a long hold-off

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
    errors++;
  endtask

  // Timeout guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("great_circle_distance_tb: errors");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus the long hold-off on request
  always @(posedge clk_i) begin : rx_driver
    int hold_left;
    int burst_left;
    if (!rst_ni) begin
      hold_left = 0;
      burst_left = 0;
      out_ready_i <= 1'b0;
    end else if (rx_hold_req && hold_left == 0) begin
      hold_left = 300;
      rx_hold_req <= 1'b0;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= (hold_left == 0);
    end else if (burst_left > 0) begin
      burst_left--;
      out_ready_i <= (burst_left == 0);
    end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
      burst_left = $urandom_range(1, 5);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Result checker: compares each taken result with the oldest prediction
  always @(posedge clk_i) begin
    logic [30:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_dist_q.size() == 0) begin
        report_mismatch("unexpected distance_cm", distance_cm_o, -1);
      end else begin
        want = pending_dist_q.pop_front();
        if (distance_cm_o !== want) report_mismatch("distance_cm", distance_cm_o, want);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender tasks; all are entered and left at a rising edge
  // ---------------------------------------------------------------------
  task automatic idle_tx(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // valid stays high after acceptance; the next request or idle_tx follows
  task automatic send_pair(longint la, longint oa, longint lb, longint ob);
    logic [30:0] want;
    if (tx_idle_en && $urandom_range(0, 3) == 0) idle_tx($urandom_range(1, 5));
    lat_a_i    <= la[30:0];
    lon_a_i    <= oa[31:0];
    lat_b_i    <= lb[30:0];
    lon_b_i    <= ob[31:0];
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // predict from what the port really carried (out-of-range values wrap)
    predict_distance(longint'(lat_a_i), longint'(lon_a_i), longint'(lat_b_i),
                     longint'(lon_b_i), want);
    pending_dist_q.push_back(want);
  endtask

  task automatic wait_drained();
    idle_tx(1);
    while (pending_dist_q.size() != 0) @(posedge clk_i);
  endtask

  // radius written only with the pipeline empty
  task automatic write_radius(longint unsigned r);
    wait_drained();
    repeat (LATENCY + 8) @(posedge clk_i);
    cfg_we_i         <= 1'b1;
    earth_radius_m_i <= r[22:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    radius_m = r & 64'h7FFFFF;
  endtask

  function automatic longint rand_lat();
    return longint'($urandom_range(0, 1800000000)) - 900000000;
  endfunction

  function automatic longint rand_lon();
    return longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
  endfunction

  // well-formed pairs mostly, some close neighbours, some raw bit noise
  task automatic send_random_pair();
    longint la, oa, lb, ob;
    int pick;
    pick = $urandom_range(0, 19);
    la = rand_lat(); oa = rand_lon();
    if (pick < 13) begin
      lb = rand_lat(); ob = rand_lon();
    end else if (pick < 17) begin
      lb = la + longint'($urandom_range(0, 20000)) - 10000;
      ob = oa + longint'($urandom_range(0, 20000)) - 10000;
    end else begin
      la = longint'($signed($urandom()));
      oa = longint'($signed($urandom()));
      lb = longint'($signed($urandom()));
      ob = longint'($signed($urandom()));
    end
    send_pair(la, oa, lb, ob);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_directed();
    send_pair(0, 0, 0, 0);                                   // same point
    send_pair(123456789, -987654321, 123456789, -987654321);
    send_pair(900000000, 0, -900000000, 0);                  // pole to pole
    send_pair(900000000, 1234567, 900000000, -1700000000);   // both at a pole
    send_pair(0, 0, 0, 1800000000);                          // antipodes
    send_pair(0, -1800000000, 0, 1800000000);                // same meridian
    send_pair(0, 1799999999, 0, -1799999999);                // dateline hop
    send_pair(450000000, 900000000, -450000000, -900000000);
    send_pair(515000000, -1200000, 515000001, -1200001);     // few cm apart
    send_pair(-900000000, -1800000000, 900000000, 1800000000);
    // field extremes, well outside the legal ranges: wrapped angles
    send_pair(-(64'sd1 << 30), -(64'sd1 << 31), (64'sd1 << 30) - 1, (64'sd1 << 31) - 1);
    send_pair((64'sd1 << 30) - 1, (64'sd1 << 31) - 1, -(64'sd1 << 30), -(64'sd1 << 31));
    send_pair(-1, -1, 1, 1);
    send_pair(0, 0, 0, 1799999999);                          // near antipode
    send_pair(899999999, 0, -899999999, 1800000000);
  endtask

  task automatic test_radius_settings();
    longint unsigned radii[6] = '{64'd6300000, 64'd6400000, 64'd0, 64'd8388607,
                                  64'd1, 64'd6371000};
    foreach (radii[r]) begin
      write_radius(radii[r]);
      send_pair(0, 0, 0, 1800000000);    // largest distance: saturates at top radius
      send_pair(0, 0, 0, 1);
      repeat (20) send_random_pair();
    end
  endtask

  task automatic test_random_traffic(int n);
    repeat (n) send_random_pair();
  endtask

  // receiver holds off long enough that the pipeline fills and stalls input
  task automatic test_backpressure();
    rx_hold_req <= 1'b1;
    repeat (300) send_random_pair();
  endtask

  // sender stops until every result is back, then carries on
  task automatic test_drain_pause();
    repeat (40) send_random_pair();
    wait_drained();
    repeat (40) send_random_pair();
  endtask

  task automatic test_full_rate();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (200) send_random_pair();
  endtask

  initial begin
    build_atan_table();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_radius_settings();
    test_random_traffic(1170);
    test_backpressure();
    test_drain_pause();
    test_full_rate();

    wait_drained();
    repeat (LATENCY + 20) @(posedge clk_i);
    if (errors == 0) begin
      $display("great_circle_distance_tb: clean");
    end else begin
      $display("great_circle_distance_tb: errors");
    end
    $finish;
  end

endmodule
